>>> hw/rtl/diameter_header_result_code_parser_unit_assert.svh
// Assertion macros shared by the Diameter header parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DIAMETER_HEADER_RESULT_CODE_PARSER_UNIT_ASSERT_SVH
`define DIAMETER_HEADER_RESULT_CODE_PARSER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define DHRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define DHRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DHRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DHRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/dhrc_pkg.sv
// Package for the Diameter header / Result-Code parser.
// Holds the AVP walk phase type, protocol constants and the result record.
package dhrc_pkg;

  localparam int unsigned PosW = 5;
  localparam logic [PosW-1:0] HdrLen = PosW'(20);
  localparam logic [31:0] TargetReset = 32'd268;
  localparam int unsigned VendorBit = 7;

  // AVP walk phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_AVP_HDR = 3'd1,
    PH_VENDOR  = 3'd2,
    PH_VALUE   = 3'd3,
    PH_SKIP    = 3'd4,
    PH_FOUND   = 3'd5,
    PH_STOPPED = 3'd6
  } phase_e;

  // One result item
  typedef struct packed {
    logic        header_ok;
    logic        is_request;
    logic [23:0] cmd_code;
    logic [31:0] app_id;
    logic [31:0] hop_by_hop;
    logic [31:0] result_value;
    logic        result_found;
  } result_t;

endpackage

>>> hw/rtl/diameter_header_result_code_parser_unit.sv
// A marked byte passes the input register and then the result register before its result is presented.
// Throughput: one byte per cycle, sustained, also while a result waits to be taken;
// the input register only holds when a marked byte meets a stalled full result register.
// Reset (async, active low): parse state cleared, no item held, target code = 268.
// Top level of the Diameter header / Result-Code parser; uses dhrc_pkg and dhrc_core.
`include "diameter_header_result_code_parser_unit_assert.svh"

module diameter_header_result_code_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        header_ok_o,
  output logic        is_request_o,
  output logic [23:0] cmd_code_o,
  output logic [31:0] app_id_o,
  output logic [31:0] hop_by_hop_o,
  output logic [31:0] result_value_o,
  output logic        result_found_o,
  // target AVP code register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_wdata_i
);
  import dhrc_pkg::*;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        s1_adv;
  logic        in_acc;
  logic [31:0] target_q;
  logic        out_valid_q;
  result_t     res;
  result_t     out_q;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else if (cfg_valid_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // input stage advances unless a marked byte has nowhere to put its result
  assign s1_adv     = s1_valid_q && !(s1_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // parse state and result logic
  dhrc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_adv),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .target_i (target_q),
    .res_o    (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign header_ok_o    = out_q.header_ok;
  assign is_request_o   = out_q.is_request;
  assign cmd_code_o     = out_q.cmd_code;
  assign app_id_o       = out_q.app_id;
  assign hop_by_hop_o   = out_q.hop_by_hop;
  assign result_value_o = out_q.result_value;
  assign result_found_o = out_q.result_found;

  // checks
  `DHRC_ASSERT_NEXT(a_res_load, clk_i, rst_ni, s1_adv && s1_last_q, out_valid_q,
                    "marked byte left no result")
  `DHRC_ASSERT_IMPL(a_stall_held, clk_i, rst_ni, !s1_valid_q, !in_stall_o,
                    "stall with empty input register")
  `DHRC_ASSERT_NEXT(a_cfg_write, clk_i, rst_ni, cfg_valid_i, target_q == $past(cfg_wdata_i),
                    "config write lost")
  `DHRC_ASSERT_IMPL(a_found_ok, clk_i, rst_ni, out_valid_q && out_q.result_found,
                    out_q.header_ok, "found without header")

endmodule

>>> hw/rtl/dhrc_core.sv
// Per-message parse state: header capture and AVP walk, one byte per fire.
// Depends on dhrc_pkg and the shared assertion macro header.
`include "diameter_header_result_code_parser_unit_assert.svh"

module dhrc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic [31:0]       target_i,
  output dhrc_pkg::result_t res_o
);
  import dhrc_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [63:0]     hdr_q, hdr_d;
  logic [7:0]      flags_q, flags_d;
  logic [23:0]     cmd_q, cmd_d;
  phase_e          phase_q, phase_d;
  logic [3:0]      idx_q, idx_d;
  logic [31:0]     code_q, code_d;
  logic [7:0]      aflags_q, aflags_d;
  logic [23:0]     alen_q, alen_d;
  logic [24:0]     skip_q, skip_d;
  logic [31:0]     val_q, val_d;
  logic [24:0]     alen_pad;
  logic            ok;
  logic            found;

  // padded AVP length, used when the AVP header completes
  assign alen_pad = ({1'b0, alen_d} + 25'd3) & ~25'd3;

  // next state for one byte
  always_comb begin
    pos_d    = pos_q;
    hdr_d    = hdr_q;
    flags_d  = flags_q;
    cmd_d    = cmd_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    code_d   = code_q;
    aflags_d = aflags_q;
    alen_d   = alen_q;
    skip_d   = skip_q;
    val_d    = val_q;
    if (pos_q < HdrLen) begin
      // fixed header bytes
      if (pos_q == PosW'(4)) begin
        flags_d = byte_i;
      end else if (pos_q >= PosW'(5) && pos_q <= PosW'(7)) begin
        cmd_d = {cmd_q[15:0], byte_i};
      end else if (pos_q >= PosW'(8) && pos_q <= PosW'(15)) begin
        hdr_d = {hdr_q[55:0], byte_i};
      end
      if (pos_q == HdrLen - PosW'(1)) begin
        pos_d   = HdrLen;
        phase_d = PH_AVP_HDR;
        idx_d   = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end else begin
      unique case (phase_q)
        PH_AVP_HDR: begin
          if (idx_q < 4'd4) begin
            code_d = {code_q[23:0], byte_i};
          end else if (idx_q == 4'd4) begin
            aflags_d = byte_i;
          end else begin
            alen_d = {alen_q[15:0], byte_i};
          end
          if (idx_q == 4'd7) begin
            idx_d = '0;
            if (alen_d < 24'd8) begin
              phase_d = PH_STOPPED;
            end else if (code_q == target_i) begin
              phase_d = aflags_q[VendorBit] ? PH_VENDOR : PH_VALUE;
            end else begin
              skip_d  = alen_pad - 25'd8;
              phase_d = (skip_d != '0) ? PH_SKIP : PH_AVP_HDR;
            end
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        PH_VENDOR: begin
          if (idx_q == 4'd3) begin
            idx_d   = '0;
            phase_d = PH_VALUE;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        PH_VALUE: begin
          val_d = {val_q[23:0], byte_i};
          if (idx_q == 4'd3) begin
            idx_d   = '0;
            phase_d = PH_FOUND;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        PH_SKIP: begin
          if (skip_q != '0) begin
            skip_d = skip_q - 25'd1;
          end
          if (skip_d == '0) begin
            phase_d = PH_AVP_HDR;
            idx_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result from the state after this byte
  assign ok    = (pos_d == HdrLen);
  assign found = ok && (phase_d == PH_FOUND);

  always_comb begin
    res_o.header_ok    = ok;
    res_o.is_request   = ok && flags_d[VendorBit];
    res_o.cmd_code     = ok ? cmd_d : '0;
    res_o.app_id       = ok ? hdr_d[63:32] : '0;
    res_o.hop_by_hop   = ok ? hdr_d[31:0] : '0;
    res_o.result_value = found ? val_d : '0;
    res_o.result_found = found;
  end

  // state registers; the marked byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_q    <= '0;
      flags_q  <= '0;
      cmd_q    <= '0;
      phase_q  <= PH_HEADER;
      idx_q    <= '0;
      code_q   <= '0;
      aflags_q <= '0;
      alen_q   <= '0;
      skip_q   <= '0;
      val_q    <= '0;
    end else if (fire_i) begin
      if (last_i) begin
        pos_q    <= '0;
        hdr_q    <= '0;
        flags_q  <= '0;
        cmd_q    <= '0;
        phase_q  <= PH_HEADER;
        idx_q    <= '0;
        code_q   <= '0;
        aflags_q <= '0;
        alen_q   <= '0;
        skip_q   <= '0;
        val_q    <= '0;
      end else begin
        pos_q    <= pos_d;
        hdr_q    <= hdr_d;
        flags_q  <= flags_d;
        cmd_q    <= cmd_d;
        phase_q  <= phase_d;
        idx_q    <= idx_d;
        code_q   <= code_d;
        aflags_q <= aflags_d;
        alen_q   <= alen_d;
        skip_q   <= skip_d;
        val_q    <= val_d;
      end
    end
  end

  // checks
  `DHRC_ASSERT_IMPL(a_pos_sat, clk_i, rst_ni, 1'b1, pos_q <= HdrLen, "byte position past header")
  `DHRC_ASSERT_IMPL(a_hdr_phase, clk_i, rst_ni, pos_q < HdrLen, phase_q == PH_HEADER,
                    "AVP walk started inside header")
  `DHRC_ASSERT_IMPL(a_walk_phase, clk_i, rst_ni, pos_q == HdrLen, phase_q != PH_HEADER,
                    "AVP walk idle after header")
  `DHRC_ASSERT_IMPL(a_skip_nz, clk_i, rst_ni, phase_q == PH_SKIP, skip_q != '0,
                    "skip phase with zero count")
  `DHRC_ASSERT_NEXT(a_clear, clk_i, rst_ni, fire_i && last_i,
                    pos_q == '0 && phase_q == PH_HEADER, "state not cleared after message")

endmodule
